// ===== src/state_variable_filter_core_assert.svh =====
// Assertion macros for the state-variable filter core.
`ifndef STATE_VARIABLE_FILTER_CORE_ASSERT_SVH
`define STATE_VARIABLE_FILTER_CORE_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication, clocked on clk_i, off during reset.
`define SVF_ASSERT(name, trig, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off during reset.
`define SVF_ASSERT_NEXT(name, trig, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`else

`define SVF_ASSERT(name, trig, cons, msg)
`define SVF_ASSERT_NEXT(name, trig, cons, msg)

`endif

`endif

// ===== src/svf_pkg.sv =====
// Shared types, constants and saturation helpers for the state-variable filter.
package svf_pkg;

  // Data widths
  localparam int SAMPLE_W = 16;
  localparam int STATE_W  = 24;
  localparam int COEF_W   = 17;
  localparam int FRAC_W   = 16;
  localparam int BASE_W   = STATE_W + 2;
  localparam int PROD_W   = STATE_W + COEF_W + 1;
  localparam int RND_W    = PROD_W - FRAC_W;
  localparam int SUM_W    = BASE_W + 1;
  localparam int CFG_IDX_W = 2;

  // Coefficient limits and reset values
  localparam logic [COEF_W-1:0] FC_MAX    = COEF_W'(58982);
  localparam logic [COEF_W-1:0] Q_MIN     = COEF_W'(3277);
  localparam logic [COEF_W-1:0] FC_RESET  = COEF_W'(5900);
  localparam logic [COEF_W-1:0] Q_RESET   = COEF_W'(65536);

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CUTOFF  = 2'd0,
    CFG_DAMPING = 2'd1,
    CFG_OUTSEL  = 2'd2
  } cfg_idx_e;

  // Output selector codes
  typedef enum logic [1:0] {
    SEL_LOW     = 2'd0,
    SEL_HIGH    = 2'd1,
    SEL_BAND    = 2'd2,
    SEL_LOW_ALT = 2'd3
  } out_sel_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_FB,
    ST_UPD_LOW,
    ST_UPD_HIGH,
    ST_MUL_HB,
    ST_UPD_BAND
  } state_e;

  // Control word from sequencer to datapath
  typedef struct packed {
    logic mul_en;     // capture a new product
    logic op_high;    // multiplicand is high-pass value, else band
    logic op_damp;    // coefficient is damping, else cutoff
    logic upd_low;
    logic upd_high;
    logic upd_band;
    logic load_out;
  } ctrl_t;

  // Saturate a wide sum to the state range
  function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'((64'sd1 <<< (STATE_W - 1)) - 64'sd1);
    lo = -hi - SUM_W'(1);
    if (v > hi) begin
      sat_state = hi[STATE_W-1:0];
    end else if (v < lo) begin
      sat_state = lo[STATE_W-1:0];
    end else begin
      sat_state = v[STATE_W-1:0];
    end
  endfunction

  // Saturate a state value to the sample range
  function automatic logic signed [SAMPLE_W-1:0] sat_sample(
    input logic signed [STATE_W-1:0] v
  );
    logic signed [STATE_W-1:0] hi;
    logic signed [STATE_W-1:0] lo;
    hi = STATE_W'((64'sd1 <<< (SAMPLE_W - 1)) - 64'sd1);
    lo = -hi - STATE_W'(1);
    if (v > hi) begin
      sat_sample = hi[SAMPLE_W-1:0];
    end else if (v < lo) begin
      sat_sample = lo[SAMPLE_W-1:0];
    end else begin
      sat_sample = v[SAMPLE_W-1:0];
    end
  endfunction

endpackage

// ===== src/svf_mac.sv =====
// Shared multiply-round-accumulate unit with registered product and saturation.
module svf_mac (
  input  logic                                clk_i,
  input  logic                                mul_en_i,
  input  logic signed [svf_pkg::STATE_W-1:0]  op_a_i,
  input  logic        [svf_pkg::COEF_W-1:0]   op_c_i,
  input  logic signed [svf_pkg::BASE_W-1:0]   base_i,
  input  logic                                sub_i,
  output logic signed [svf_pkg::STATE_W-1:0]  sum_o
);
  import svf_pkg::*;

  localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(64'sd1 <<< (FRAC_W - 1));

  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic signed [PROD_W-1:0] prod_rnd;
  logic signed [RND_W-1:0]  scaled;
  logic signed [SUM_W-1:0]  base_ext, scaled_ext, sum;

  // Product of state value and unsigned coefficient
  assign prod_d = PROD_W'($signed(op_a_i)) * PROD_W'($signed({1'b0, op_c_i}));

  always_ff @(posedge clk_i) begin
    if (mul_en_i) begin
      prod_q <= prod_d;
    end
  end

  // Divide by 2^16, rounding half up
  assign prod_rnd = prod_q + RND_HALF;
  assign scaled   = prod_rnd[PROD_W-1:FRAC_W];

  // Accumulate and clamp to state range
  assign base_ext   = SUM_W'(base_i);
  assign scaled_ext = SUM_W'(scaled);
  assign sum        = sub_i ? (base_ext - scaled_ext) : (base_ext + scaled_ext);
  assign sum_o      = sat_state(sum);

endmodule

// ===== src/svf_seq.sv =====
// Sequencer that steps the shared unit through one filter update.
module svf_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           idle_o,
  output svf_pkg::ctrl_t ctrl_o
);
  import svf_pkg::*;

  state_e state_d, state_q;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (start_i) state_d = ST_MUL_FB;
      ST_MUL_FB:   state_d = ST_UPD_LOW;
      ST_UPD_LOW:  state_d = ST_UPD_HIGH;
      ST_UPD_HIGH: state_d = ST_MUL_HB;
      ST_MUL_HB:   state_d = ST_UPD_BAND;
      ST_UPD_BAND: state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Control outputs per step
  always_comb begin
    ctrl_o = '0;
    idle_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        idle_o = 1'b1;
      end
      ST_MUL_FB: begin
        ctrl_o.mul_en = 1'b1;            // band * fc
      end
      ST_UPD_LOW: begin
        ctrl_o.upd_low = 1'b1;
        ctrl_o.mul_en  = 1'b1;           // band * q, band still old
        ctrl_o.op_damp = 1'b1;
      end
      ST_UPD_HIGH: begin
        ctrl_o.upd_high = 1'b1;
      end
      ST_MUL_HB: begin
        ctrl_o.mul_en  = 1'b1;           // high * fc
        ctrl_o.op_high = 1'b1;
      end
      ST_UPD_BAND: begin
        ctrl_o.upd_band = 1'b1;
        ctrl_o.load_out = 1'b1;
      end
      default: begin
        ctrl_o = '0;
      end
    endcase
  end

endmodule

// ===== src/state_variable_filter_core.sv =====
// Top level of the fixed-point Chamberlin state-variable filter core.
//
// One signed 16-bit sample in, one selected filter output (low, high or band pass)
// out per beat. Each sample passes from an accept step through three products
// (band*fc, band*q, high*fc) that run one after another through a single shared
// 24x18 multiplier, each product registered and then rounded, accumulated and
// saturated, before its result beat. The input side is ready only while the
// sequencer is idle and the output register is empty or being drained, so a new
// sample is not taken until the sequencer is through with the last one. Coefficients are
// clamped when written (fc to 0.9, damping to at least 0.05); write
// configuration only while the filter is idle.
`include "state_variable_filter_core_assert.svh"

module state_variable_filter_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Configuration write port
  input  logic                                 cfg_we_i,
  input  logic [svf_pkg::CFG_IDX_W-1:0]        cfg_addr_i,
  input  logic [svf_pkg::COEF_W-1:0]           cfg_wdata_i,
  // Input stream
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  logic [svf_pkg::SAMPLE_W-1:0]         s_axis_tdata_i,   // [15:0] sample_in
  // Output stream
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  output logic [svf_pkg::SAMPLE_W-1:0]         m_axis_tdata_o    // [15:0] sample_out
);
  import svf_pkg::*;

  ctrl_t ctrl;
  logic  idle;
  logic  in_beat;

  logic [COEF_W-1:0]          fc_q, damp_q;
  logic [1:0]                 sel_q;
  logic signed [SAMPLE_W-1:0] x_q;
  logic signed [STATE_W-1:0]  low_q, band_q, high_q;
  logic                       out_valid_q;
  logic signed [SAMPLE_W-1:0] out_q;

  logic signed [STATE_W-1:0]  op_a;
  logic [COEF_W-1:0]          op_c;
  logic signed [BASE_W-1:0]   base;
  logic signed [STATE_W-1:0]  mac_sum;
  logic signed [STATE_W-1:0]  sel_val;

  // Handshake
  assign s_axis_tready_o = idle && (!out_valid_q || m_axis_tready_i);
  assign in_beat         = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

  // Configuration registers, clamped on write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_q   <= FC_RESET;
      damp_q <= Q_RESET;
      sel_q  <= SEL_LOW;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_CUTOFF: begin
          fc_q <= ({1'b0, cfg_wdata_i[COEF_W-2:0]} > FC_MAX) ?
                  FC_MAX : {1'b0, cfg_wdata_i[COEF_W-2:0]};
        end
        CFG_DAMPING: begin
          damp_q <= (cfg_wdata_i < Q_MIN) ? Q_MIN : cfg_wdata_i;
        end
        CFG_OUTSEL: begin
          sel_q <= cfg_wdata_i[1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Sequencer
  svf_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_beat),
    .idle_o  (idle),
    .ctrl_o  (ctrl)
  );

  // Operand and accumulator-base selection for the shared unit
  assign op_a = ctrl.op_high ? high_q : band_q;
  assign op_c = ctrl.op_damp ? damp_q : fc_q;

  always_comb begin
    if (ctrl.upd_high) begin
      base = BASE_W'(x_q) - BASE_W'(low_q);
    end else if (ctrl.upd_band) begin
      base = BASE_W'(band_q);
    end else begin
      base = BASE_W'(low_q);
    end
  end

  svf_mac u_mac (
    .clk_i    (clk_i),
    .mul_en_i (ctrl.mul_en),
    .op_a_i   (op_a),
    .op_c_i   (op_c),
    .base_i   (base),
    .sub_i    (ctrl.upd_high),
    .sum_o    (mac_sum)
  );

  // Sample register
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      x_q <= s_axis_tdata_i;
    end
  end

  // Integrator state and high-pass value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= '0;
      band_q <= '0;
    end else begin
      if (ctrl.upd_low) begin
        low_q <= mac_sum;
      end
      if (ctrl.upd_band) begin
        band_q <= mac_sum;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.upd_high) begin
      high_q <= mac_sum;
    end
  end

  // Output selection, band uses the value being written this cycle
  always_comb begin
    case (sel_q)
      SEL_HIGH: sel_val = high_q;
      SEL_BAND: sel_val = mac_sum;
      default:  sel_val = low_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.load_out) begin
      out_q <= sat_sample(sel_val);
    end
  end

  // Checks
  `SVF_ASSERT_NEXT(a_busy_after_accept, in_beat, !s_axis_tready_o, "accepted while busy")
  `SVF_ASSERT(a_out_slot_free, ctrl.load_out, !out_valid_q || m_axis_tready_i, "result overwrites beat")
  `SVF_ASSERT_NEXT(a_result_shown, ctrl.upd_band, m_axis_tvalid_o, "result beat missing")
  `SVF_ASSERT(a_one_update, 1'b1, $onehot0({ctrl.upd_low, ctrl.upd_high, ctrl.upd_band}), "two updates at once")

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the fixed-point state-variable filter core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import svf_pkg::*;

  localparam int       IDLE_LIMIT   = 2000;  // cycles without any beat before giving up
  localparam int       DRAIN_CYCLES = 12;    // longer than one sample takes from acceptance to its result
  localparam int       RAND_PHASES  = 10;
  localparam int       PHASE_ITEMS  = 40;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // Shadow of the filter: registers, integrators and the outputs still owed
  class filter_shadow;
    logic [15:0]         fc_reg;
    logic [16:0]         q_reg;
    out_sel_e            sel_reg;
    longint              low_acc;
    longint              band_acc;
    logic [SAMPLE_W-1:0] pending_out[$];
    int                  errors;

    function new();
      fc_reg   = FC_RESET[15:0];
      q_reg    = Q_RESET;
      sel_reg  = SEL_LOW;
      low_acc  = 0;
      band_acc = 0;
      errors   = 0;
    endfunction

    // Clip to a signed range of the given width
    function longint clip(longint v, int bits);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (bits - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    // state * coefficient / 2^16, rounded half up
    function longint coef_mul(longint a, longint c);
      longint p;
      p = a * c + 32768;
      return p >>> 16;
    endfunction

    function void apply_write(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] val);
      case (idx)
        CFG_CUTOFF:  fc_reg  = val[15:0];
        CFG_DAMPING: q_reg   = val;
        CFG_OUTSEL:  sel_reg = out_sel_e'(val[1:0]);
        default: ;
      endcase
    endfunction

    // One filter step per accepted input beat
    function void take_sample(logic signed [SAMPLE_W-1:0] s);
      longint fc;
      longint q;
      longint x;
      longint hp;
      longint y;
      fc = (fc_reg > FC_MAX) ? longint'(FC_MAX) : longint'(fc_reg);
      q  = (q_reg < Q_MIN) ? longint'(Q_MIN) : longint'(q_reg);
      x  = s;
      low_acc  = clip(low_acc + coef_mul(band_acc, fc), STATE_W);
      hp       = clip(x - low_acc - coef_mul(band_acc, q), STATE_W);
      band_acc = clip(band_acc + coef_mul(hp, fc), STATE_W);
      case (sel_reg)
        SEL_HIGH: y = hp;
        SEL_BAND: y = band_acc;
        default:  y = low_acc;
      endcase
      y = clip(y, SAMPLE_W);
      pending_out.push_back(y[SAMPLE_W-1:0]);
    endfunction

    function void check_output(logic [SAMPLE_W-1:0] act);
      logic [SAMPLE_W-1:0] exp_val;
      if (pending_out.size() == 0) begin
        errors++;
        $display("%0t: output beat %0d with nothing pending", $time, $signed(act));
      end else begin
        exp_val = pending_out.pop_front();
        if (act !== exp_val) begin
          errors++;
          $display("%0t: sample_out mismatch, expected %0d, got %0d",
                   $time, $signed(exp_val), $signed(act));
        end
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_addr_i;
  logic [COEF_W-1:0]    cfg_wdata_i;
  logic                 s_axis_tvalid_i;
  logic                 s_axis_tready_o;
  logic [SAMPLE_W-1:0]  s_axis_tdata_i;   // [15:0] sample_in
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i;
  logic [SAMPLE_W-1:0]  m_axis_tdata_o;   // [15:0] sample_out

  filter_shadow shadow = new();
  int           src_idle_pct;
  int           sink_stall_pct;
  int           stall_left;
  int           quiet_cycles;

  state_variable_filter_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // 12 ns clock
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Mostly short gaps, now and then a long one
  function automatic int rand_gap();
    if ($urandom_range(99) < 80) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Output side back-pressure
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_left > 0) begin
        m_axis_tready_i <= 1'b0;
        stall_left--;
      end else if (sink_stall_pct != 0 && $urandom_range(99) < sink_stall_pct) begin
        m_axis_tready_i <= 1'b0;
        stall_left = rand_gap() - 1;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // Register writes, output checks and input beats, in one fixed order
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) shadow.apply_write(cfg_addr_i, cfg_wdata_i);
      if (m_axis_tvalid_o && m_axis_tready_i) shadow.check_output(m_axis_tdata_o);
      if (s_axis_tvalid_i && s_axis_tready_o) shadow.take_sample(s_axis_tdata_i);
    end
  end

  // Watchdog on cycles with no beat on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT) begin
          $display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
          $display("FAIL");
          $finish;
        end
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat
  task automatic send_sample(input logic [SAMPLE_W-1:0] s);
    int gap;
    gap = (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) ? rand_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= s;
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
  endtask

  // Register write; waits again after dropping the enable so it never toggles twice in a step
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Stop sending and wait until the filter is idle
  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    while (shadow.pending_out.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    int r;
    r = $urandom_range(99);
    if (r < 50) return SAMPLE_W'($urandom);
    if (r < 80) return SAMPLE_W'($urandom_range(2000) - 1000);
    if (r < 90) return 16'h7fff;
    return 16'h8000;
  endfunction

  initial begin
    logic [COEF_W-1:0] fc_val;
    logic [COEF_W-1:0] q_val;
    int                r;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_addr_i      = CFG_CUTOFF;
    cfg_wdata_i     = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    m_axis_tready_i = 1'b0;
    src_idle_pct    = 0;
    sink_stall_pct  = 0;
    stall_left      = 0;
    quiet_cycles    = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset settings: sample extremes through the low-pass
    send_sample(16'h7fff);
    send_sample(16'h8000);
    send_sample(16'h0000);
    send_sample(16'hffff);
    settle();

    // fc written with a dropped top bit and above the clamp, damping below its floor
    write_reg(CFG_CUTOFF, 17'h1ffff);
    write_reg(CFG_DAMPING, 17'h00000);
    write_reg(CFG_OUTSEL, COEF_W'(SEL_HIGH));
    send_sample(16'h5555);
    send_sample(16'haaaa);
    settle();

    // Damping near two makes the loop unstable and drives the integrators into saturation
    write_reg(CFG_UNUSED, 17'h00000);
    write_reg(CFG_DAMPING, 17'h1ffff);
    write_reg(CFG_OUTSEL, COEF_W'(SEL_BAND));
    for (int i = 0; i < 18; i++) send_sample(i[0] ? 16'h8000 : 16'h7fff);
    settle();

    // Selector three falls back to low-pass
    write_reg(CFG_OUTSEL, 17'h1fffb);
    send_sample(16'h7fff);
    send_sample(16'h0001);
    settle();

    // Random settings, samples and idling
    for (int p = 0; p < RAND_PHASES; p++) begin
      r = $urandom_range(99);
      if (r < 20) fc_val = 17'h0ffff;
      else if (r < 30) fc_val = 17'h00000;
      else if (r < 40) fc_val = COEF_W'($urandom_range(65535, 58982));
      else fc_val = COEF_W'($urandom_range(30000, 200));
      fc_val[16] = 1'($urandom_range(1));
      r = $urandom_range(99);
      if (r < 15) q_val = COEF_W'($urandom_range(3277));
      else if (r < 25) q_val = COEF_W'($urandom_range(131071, 65537));
      else q_val = COEF_W'($urandom_range(65536, 3277));
      write_reg(CFG_CUTOFF, fc_val);
      write_reg(CFG_DAMPING, q_val);
      write_reg(CFG_OUTSEL, COEF_W'($urandom));
      if ($urandom_range(99) < 30) write_reg(CFG_UNUSED, COEF_W'($urandom));
      case (p % 3)
        0: begin
          src_idle_pct   = 0;
          sink_stall_pct = 0;
        end
        1: begin
          src_idle_pct   = 30;
          sink_stall_pct = 30;
        end
        default: begin
          src_idle_pct   = 70;
          sink_stall_pct = 50;
        end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) send_sample(rand_sample());
      settle();
    end

    // settle() has already drained; give stray beats a chance to show up
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (shadow.pending_out.size() != 0) begin
      $display("%0t: %0d outputs never arrived", $time, shadow.pending_out.size());
    end
    if (shadow.errors == 0 && shadow.pending_out.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
